[hw/rtl/wdl_pkg.sv]
// ----------------------------------------------------------------------------
// wdl_pkg: shared types and constants of the word dictionary lookup
// Item layouts, command and status codes, queue entry and the case-folding
// character compare.
// ----------------------------------------------------------------------------
package wdl_pkg;

    localparam int DICT_BYTES_DEF = 16384;
    localparam int NAME_MAX_DEF   = 31;
    localparam int VALUE_BITS_DEF = 32;

    localparam int VALUE_W  = 32;   // width of the value field on the ports
    localparam int RESULT_W = 32;
    localparam int CNT_W    = 8;    // covers any name length up to 255

    localparam logic [7:0] FOLD_STEP   = 8'h20;
    localparam logic [7:0] UPPER_LIMIT = 8'h5A;   // 'Z'

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_LONG = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [7:0]         ch;
        logic               last;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [RESULT_W-1:0] result_value;
        t_status             status;
    } t_out_item;

    // One complete name handed from the front to the back
    typedef struct packed {
        t_cmd               cmd;
        logic               too_long;
        logic [CNT_W-1:0]   count;
        logic               bank;
        logic [VALUE_W-1:0] value;
    } t_queue_entry;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_INS,
        BE_LEN,
        BE_CMP,
        BE_VAL,
        BE_NEXT
    } t_be_state;

    // Case-folding match: a code above 'Z' equals the code 0x20 below it
    function automatic logic chars_match(input logic [7:0] a, input logic [7:0] b);
        logic eq;
        logic fa;
        logic fb;
        eq = (a == b);
        fa = (a > UPPER_LIMIT) && ((a - FOLD_STEP) == b);
        fb = (b > UPPER_LIMIT) && ((b - FOLD_STEP) == a);
        return eq || fa || fb;
    endfunction

endpackage

[hw/rtl/wdl_front.sv]
// ----------------------------------------------------------------------------
// wdl_front: name collection
// Accepts character items, stores them in a two-bank name buffer and pushes
// one queue entry per complete name.
// ----------------------------------------------------------------------------
module wdl_front import wdl_pkg::*; #(
    parameter int NAME_MAX = NAME_MAX_DEF,
    localparam int IW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_full,
    input  t_in_item     i_item,
    output logic         o_push,
    output t_queue_entry o_entry,
    input  logic [IW:0]  i_rd_addr,
    output logic [7:0]   o_rd_data
);

    localparam int NW         = $clog2(NAME_MAX + 1);
    localparam int NAME_DEPTH = 2 ** (IW + 1);

    logic [7:0]    r_name_mem [0:NAME_DEPTH-1];
    logic [7:0]    r_rd_data;
    logic [NW-1:0] r_count;
    logic          r_long;
    logic          r_bank;

    logic          w_accept;
    logic          w_room;
    logic [NW-1:0] w_count_inc;

    assign w_accept    = i_start && !i_full;
    assign w_room      = (r_count < NW'(NAME_MAX));
    assign w_count_inc = w_room ? (r_count + 1'b1) : r_count;

    // Buffer: written by the front, read by the back through a registered port
    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_name_mem[{r_bank, r_count[IW-1:0]}] <= i_item.ch;
        end
        r_rd_data <= r_name_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_long  <= 1'b0;
            r_bank  <= 1'b0;
        end else if (w_accept) begin
            if (i_item.last) begin
                r_count <= '0;
                r_long  <= 1'b0;
                r_bank  <= !r_bank;
            end else begin
                r_count <= w_count_inc;
                r_long  <= r_long || !w_room;
            end
        end
    end

    assign o_push            = w_accept && i_item.last;
    assign o_entry.cmd       = i_item.cmd;
    assign o_entry.too_long  = r_long || !w_room;
    assign o_entry.count     = CNT_W'(w_count_inc);
    assign o_entry.bank      = r_bank;
    assign o_entry.value     = i_item.value;
    assign o_rd_data         = r_rd_data;

endmodule

[hw/rtl/wdl_queue.sv]
// ----------------------------------------------------------------------------
// wdl_queue: two-entry command queue
// Holds complete names between the front and the back; the head stays in
// place until the back has finished with it.
// ----------------------------------------------------------------------------
module wdl_queue import wdl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_queue_entry i_entry,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output t_queue_entry o_head,
    output logic [1:0]   o_count
);

    t_queue_entry r_slot [0:1];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot[r_rp];
    assign o_count = r_cnt;

endmodule

[hw/rtl/wdl_back.sv]
// ----------------------------------------------------------------------------
// wdl_back: dictionary engine
// Owns the byte-packed dictionary memory; appends records on insert and
// scans all records on lookup, one memory byte per cycle.
// ----------------------------------------------------------------------------
module wdl_back import wdl_pkg::*; #(
    parameter int DICT_BYTES = DICT_BYTES_DEF,
    parameter int NAME_MAX   = NAME_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_queue_entry i_head,
    output logic         o_pop,
    output logic [IW:0]  o_name_addr,
    input  logic [7:0]   i_name_data,
    output logic         o_strobe,
    output t_out_item    o_result
);

    localparam int VB   = (VALUE_BITS + 7) / 8;
    localparam int VBW  = 8 * VB;
    localparam int KEEP = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int AW   = $clog2(DICT_BYTES);
    localparam int EW   = $clog2(DICT_BYTES + 1);
    localparam int KW   = $clog2(NAME_MAX + VB + 2);
    localparam int SW   = ((EW > KW) ? EW : KW) + 2;
    localparam int LANES = RESULT_W / 8;

    logic [7:0]          r_dict [0:DICT_BYTES-1];
    logic [7:0]          r_rdata;

    t_be_state           r_state, n_state;
    logic [EW-1:0]       r_end, n_end;
    logic [EW-1:0]       r_pos, n_pos;
    logic [EW-1:0]       r_next, n_next;
    logic [EW-1:0]       r_addr, n_addr;
    logic [KW-1:0]       r_k, n_k;
    logic [VBW-1:0]      r_val, n_val;
    logic                r_hit, n_hit;
    logic [RESULT_W-1:0] r_res, n_res;
    logic                r_strobe, n_strobe;
    t_out_item           r_out, n_out;

    logic                w_we;
    logic [EW-1:0]       w_waddr;
    logic [7:0]          w_wdata;
    logic [EW-1:0]       w_raddr;
    logic [IW-1:0]       w_name_idx;
    logic [KW-1:0]       w_k_inc;
    logic [SW-1:0]       w_need;
    logic [SW-1:0]       w_room;
    logic [KEEP-1:0]     w_val_keep;

    assign w_k_inc    = r_k + 1'b1;
    assign w_need     = SW'(1) + SW'(i_head.count) + SW'(VB);
    assign w_room     = SW'(DICT_BYTES) - SW'(r_end);
    assign w_val_keep = i_head.value[KEEP-1:0];

    // Dictionary memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_dict[w_waddr[AW-1:0]] <= w_wdata;
        end
        r_rdata <= r_dict[w_raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BE_IDLE;
            r_end    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_end    <= n_end;
            r_strobe <= n_strobe;
        end
        r_pos  <= n_pos;
        r_next <= n_next;
        r_addr <= n_addr;
        r_k    <= n_k;
        r_val  <= n_val;
        r_hit  <= n_hit;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_end      = r_end;
        n_pos      = r_pos;
        n_next     = r_next;
        n_addr     = r_addr;
        n_k        = r_k;
        n_val      = r_val;
        n_hit      = r_hit;
        n_res      = r_res;
        n_strobe   = 1'b0;
        n_out      = r_out;
        o_pop      = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_addr;
        w_wdata    = r_val[7:0];
        w_raddr    = '0;
        w_name_idx = '0;

        unique case (r_state)
            BE_IDLE: begin
                if (i_valid) begin
                    priority if (i_head.too_long) begin
                        n_strobe = 1'b1;
                        n_out    = '{found: 1'b0, result_value: '0, status: ST_LONG};
                        o_pop    = 1'b1;
                    end else if (i_head.cmd == CMD_INSERT) begin
                        if (w_need > w_room) begin
                            n_strobe = 1'b1;
                            n_out    = '{found: 1'b0, result_value: '0, status: ST_FULL};
                            o_pop    = 1'b1;
                        end else begin
                            n_addr  = r_end;
                            n_k     = '0;
                            n_val   = VBW'(w_val_keep);
                            n_state = BE_INS;
                        end
                    end else begin
                        n_hit = 1'b0;
                        n_res = '0;
                        if (r_end == '0) begin
                            n_strobe = 1'b1;
                            n_out    = '{found: 1'b0, result_value: '0, status: ST_OK};
                            o_pop    = 1'b1;
                        end else begin
                            n_pos   = '0;
                            w_raddr = '0;
                            n_state = BE_LEN;
                        end
                    end
                end
            end

            BE_INS: begin
                // length byte, then name bytes, then value bytes low first
                w_we       = 1'b1;
                w_name_idx = r_k[IW-1:0];
                priority if (r_k == '0) begin
                    w_wdata = i_head.count;
                end else if (SW'(r_k) <= SW'(i_head.count)) begin
                    w_wdata = i_name_data;
                end else begin
                    w_wdata = r_val[7:0];
                    n_val   = r_val >> 8;
                end
                n_addr = r_addr + 1'b1;
                n_k    = w_k_inc;
                if (SW'(w_k_inc) == w_need) begin
                    n_end    = r_addr + 1'b1;
                    n_strobe = 1'b1;
                    n_out    = '{found: 1'b0, result_value: '0, status: ST_OK};
                    o_pop    = 1'b1;
                    n_state  = BE_IDLE;
                end
            end

            BE_LEN: begin
                n_next     = r_pos + EW'(1) + EW'(r_rdata) + EW'(VB);
                w_raddr    = r_pos + 1'b1;
                n_addr     = r_pos + EW'(2);
                w_name_idx = '0;
                n_k        = '0;
                if (r_rdata == i_head.count) begin
                    if (i_head.count == '0) begin
                        n_hit   = 1'b1;
                        n_res   = '0;
                        n_state = BE_VAL;
                    end else begin
                        n_state = BE_CMP;
                    end
                end else begin
                    n_state = BE_NEXT;
                end
            end

            BE_CMP: begin
                w_raddr    = r_addr;
                n_addr     = r_addr + 1'b1;
                w_name_idx = w_k_inc[IW-1:0];
                if (!chars_match(i_name_data, r_rdata)) begin
                    n_state = BE_NEXT;
                end else if (w_k_inc == KW'(i_head.count)) begin
                    n_hit   = 1'b1;
                    n_res   = '0;
                    n_k     = '0;
                    n_state = BE_VAL;
                end else begin
                    n_k = w_k_inc;
                end
            end

            BE_VAL: begin
                w_raddr = r_addr;
                n_addr  = r_addr + 1'b1;
                for (int l = 0; l < LANES; l++) begin
                    if (r_k == KW'(l)) begin
                        n_res[8*l +: 8] = r_rdata;
                    end
                end
                if (r_k == KW'(VB - 1)) begin
                    n_state = BE_NEXT;
                end else begin
                    n_k = w_k_inc;
                end
            end

            BE_NEXT: begin
                n_pos = r_next;
                if (r_next >= r_end) begin
                    n_strobe = 1'b1;
                    n_out    = '{found: r_hit, result_value: r_res, status: ST_OK};
                    o_pop    = 1'b1;
                    n_state  = BE_IDLE;
                end else begin
                    w_raddr = r_next;
                    n_state = BE_LEN;
                end
            end

            default: begin
                n_state = BE_IDLE;
            end
        endcase
    end

    assign o_name_addr = {i_head.bank, w_name_idx};
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;

endmodule

[hw/rtl/word_dictionary_lookup.sv]
// ----------------------------------------------------------------------------
// word_dictionary_lookup: case-folding name dictionary
// Names arrive one character per item; the last character triggers an insert
// or a lookup against a byte-packed record store.
// ----------------------------------------------------------------------------
// A character item is taken whenever busy is low. Each name's
// command runs in the dictionary engine behind a two-entry queue, so a new
// name can be typed in while the previous one is still being carried out;
// busy rises only while two complete names wait. The dictionary memory has a
// single read/write port, so the engine handles one byte per cycle. An insert
// writes the length byte, the name and the value bytes; a rejected insert, an
// over-long name or a lookup on an empty store is answered from the idle
// state; a lookup reads the length byte of every stored record, the name
// bytes of every record whose length equals the name's up to the first
// mismatch, and the value bytes of every match. The result is registered and
// shows in the cycle after the engine finishes the command. Each result shows
// on o_result for exactly one cycle with o_strobe high and must be taken then;
// results come in the order the names were given. No clearing pass follows
// reset: only bytes already written are ever read.
// ----------------------------------------------------------------------------
module word_dictionary_lookup import wdl_pkg::*; #(
    parameter int DICT_BYTES = DICT_BYTES_DEF,
    parameter int NAME_MAX   = NAME_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int IW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    logic         w_push;
    t_queue_entry w_entry;
    logic         w_pop;
    logic         w_full;
    logic         w_valid;
    t_queue_entry w_head;
    logic [1:0]   w_q_count;
    logic [IW:0]  w_name_addr;
    logic [7:0]   w_name_data;

    // Front: collect characters, push one entry per name
    wdl_front #(
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_full    (w_full),
        .i_item    (i_item),
        .o_push    (w_push),
        .o_entry   (w_entry),
        .i_rd_addr (w_name_addr),
        .o_rd_data (w_name_data)
    );

    // Queue: hold finished names until the engine drops them
    wdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_head  (w_head),
        .o_count (w_q_count)
    );

    // Back: insert or scan, then report
    wdl_back #(
        .DICT_BYTES (DICT_BYTES),
        .NAME_MAX   (NAME_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_name_addr (w_name_addr),
        .i_name_data (w_name_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // Hold off new characters while both name banks are spoken for
    assign busy = w_full;

`ifndef NO_ASSERTIONS
    a_found_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.found |-> o_result.status == ST_OK)
        else $error("found result carries an error status");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.found |-> o_result.result_value == '0)
        else $error("result without a match carries a value");

    a_result_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_pop) && ($past(w_q_count) != 2'd0))
        else $error("result not preceded by a queue entry retiring");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the word dictionary lookup
// Streams names one character per item into the block, predicts each insert
// and lookup answer from a local byte-level copy of the dictionary, and checks
// every strobed result against the oldest pending answer. The run covers
// case-folded matches, duplicates and over-long names.
// ----------------------------------------------------------------------------
module tb;
    import wdl_pkg::*;

    localparam int VALUE_BYTES = (VALUE_BITS_DEF + 7) / 8;
    localparam int POOL_SIZE   = 64;
    localparam int WORD_MAX    = 48;

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_strobe;
    t_out_item o_result;

    word_dictionary_lookup dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Dictionary model: records are a length byte, the name bytes and the
    // value in little-endian byte order, packed back to back from address 0
    // ------------------------------------------------------------------------
    logic [7:0]  dict_bytes [DICT_BYTES_DEF];
    int unsigned dict_used     = 0;
    logic [7:0]  name_chars [NAME_MAX_DEF];
    int unsigned name_len      = 0;
    bit          name_overflow = 1'b0;

    t_out_item   answers_due [$];   // predicted results, oldest first
    t_in_item    char_stream [$];   // items waiting to be driven

    int items_queued = 0;
    int items_sent   = 0;
    int items_taken  = 0;
    int phase1_end   = 0;
    int phase2_end   = 0;
    int mismatches   = 0;
    bit took_item    = 1'b0;

    // Case-folding compare: a code above 'Z' also equals the code 0x20 below
    function automatic bit fold_eq(logic [7:0] a, logic [7:0] b);
        return (a == b) ||
               (a > UPPER_LIMIT && (a - FOLD_STEP) == b) ||
               (b > UPPER_LIMIT && (b - FOLD_STEP) == a);
    endfunction

    // Absorb one accepted character; on the last one, run the command and
    // queue the answer the block owes for it
    task automatic take_char(t_in_item it);
        t_out_item   r;
        int unsigned need;
        int unsigned pos;
        int unsigned rlen;
        int unsigned k;
        bit          hit;
        if (name_len < NAME_MAX_DEF) begin
            name_chars[name_len] = it.ch;
            name_len++;
        end else begin
            name_overflow = 1'b1;
        end
        if (it.last) begin
            r = '0;
            r.status = ST_OK;
            if (name_overflow) begin
                r.status = ST_LONG;
            end else if (it.cmd == CMD_INSERT) begin
                need = 1 + name_len + VALUE_BYTES;
                if (need > DICT_BYTES_DEF - dict_used) begin
                    r.status = ST_FULL;
                end else begin
                    dict_bytes[dict_used] = 8'(name_len);
                    for (k = 0; k < name_len; k++)
                        dict_bytes[dict_used + 1 + k] = name_chars[k];
                    for (k = 0; k < VALUE_BYTES; k++)
                        dict_bytes[dict_used + 1 + name_len + k] = it.value[8*k +: 8];
                    dict_used += need;
                end
            end else begin
                // Scan every record; a later match overrides an earlier one
                pos = 0;
                while (pos < dict_used) begin
                    rlen = dict_bytes[pos];
                    if (rlen == name_len) begin
                        hit = 1'b1;
                        for (k = 0; k < rlen; k++)
                            if (!fold_eq(name_chars[k], dict_bytes[pos + 1 + k]))
                                hit = 1'b0;
                        if (hit) begin
                            r.found = 1'b1;
                            for (k = 0; k < VALUE_BYTES; k++)
                                r.result_value[8*k +: 8] = dict_bytes[pos + 1 + rlen + k];
                        end
                    end
                    pos += 1 + rlen + VALUE_BYTES;
                end
            end
            name_len      = 0;
            name_overflow = 1'b0;
            answers_due.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Load the next item once the
    // current one has been taken, or idle at the phase's rate.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int unsigned gap_pct;
        if (i_rst_n && (!start || took_item)) begin
            took_item = 1'b0;
            gap_pct = (items_sent < phase1_end) ? 34 : (items_sent < phase2_end) ? 54 : 0;
            if (char_stream.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
                i_item <= char_stream.pop_front();
                start  <= 1'b1;
                items_sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Acceptance and result check on the rising edge. Predict first so that
    // a result strobed at the edge that takes its last item still finds its
    // answer waiting.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (start && !busy) begin
                take_char(i_item);
                items_taken++;
                took_item = 1'b1;
            end
            if (o_strobe === 1'b1) begin
                if (answers_due.size() == 0) begin
                    $error("result with no name pending: found=%0b value=%h status=%0d",
                           o_result.found, o_result.result_value, o_result.status);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_result.found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, o_result.found);
                        mismatches++;
                    end
                    if (o_result.result_value !== want.result_value) begin
                        $error("result_value: expected %h, actual %h",
                               want.result_value, o_result.result_value);
                        mismatches++;
                    end
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_result.status);
                        mismatches++;
                    end
                end
            end else if (o_strobe !== 1'b0) begin
                $error("o_strobe unknown after reset");
                mismatches++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Name building
    // ------------------------------------------------------------------------
    logic [7:0] word_buf [WORD_MAX];
    int         word_len = 0;
    logic [7:0] pool_chars [POOL_SIZE][NAME_MAX_DEF];
    int         pool_len [POOL_SIZE];
    int         pool_fill = 0;
    int         pool_next = 0;

    // Mostly letters, some codes around the fold edge, the rest anything
    function automatic logic [7:0] rand_char();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 30)
            return 8'h41 + 8'($urandom_range(25, 0));
        else if (pick < 60)
            return 8'h61 + 8'($urandom_range(25, 0));
        else if (pick < 75)
            return 8'h30 + 8'($urandom_range(79, 0));
        return 8'($urandom_range(255, 0));
    endfunction

    // Swap to the folded partner half of the time, where one exists
    function automatic logic [7:0] flip_case(logic [7:0] c);
        if ($urandom_range(1, 0) == 0)
            return c;
        if (c > UPPER_LIMIT)
            return c - FOLD_STEP;
        if (c > 8'h3A && c < 8'hE0)
            return c + FOLD_STEP;
        return c;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_len();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 70)
            return $urandom_range(6, 1);
        else if (pick < 90)
            return $urandom_range(NAME_MAX_DEF - 1, 7);
        return NAME_MAX_DEF;
    endfunction

    task automatic make_word(int len);
        int k;
        word_len = len;
        for (k = 0; k < len; k++)
            word_buf[k] = rand_char();
    endtask

    task automatic remember_word();
        int k;
        pool_len[pool_next] = word_len;
        for (k = 0; k < word_len; k++)
            pool_chars[pool_next][k] = word_buf[k];
        pool_next = (pool_next + 1) % POOL_SIZE;
        if (pool_fill < POOL_SIZE)
            pool_fill++;
    endtask

    task automatic recall_word();
        int j;
        int k;
        j = $urandom_range(pool_fill - 1, 0);
        word_len = pool_len[j];
        for (k = 0; k < word_len; k++)
            word_buf[k] = flip_case(pool_chars[j][k]);
    endtask

    // Queue the name in word_buf; cmd and value only count on its last item,
    // so randomize them on the others
    task automatic queue_word(t_cmd cmd, logic [31:0] value);
        t_in_item it;
        int       k;
        for (k = 0; k < word_len; k++) begin
            it.last  = (k == word_len - 1);
            it.ch    = word_buf[k];
            it.cmd   = it.last ? cmd : ($urandom_range(1, 0) ? CMD_LOOKUP : CMD_INSERT);
            it.value = it.last ? value : $urandom();
            char_stream.push_back(it);
        end
        items_queued += word_len;
    endtask

    task automatic queue_random_name();
        int pick;
        int j;
        pick = $urandom_range(99, 0);
        if (pick < 35 || pool_fill == 0) begin
            make_word(rand_len());
            remember_word();
            queue_word(CMD_INSERT, rand_value());
        end else if (pick < 45) begin
            // rebind a known name, possibly spelled in the other case
            recall_word();
            queue_word(CMD_INSERT, rand_value());
        end else if (pick < 75) begin
            recall_word();
            queue_word(CMD_LOOKUP, $urandom());
        end else if (pick < 85) begin
            // near miss: drop the last character or flip one bit
            recall_word();
            if (word_len > 1 && $urandom_range(1, 0) == 1) begin
                word_len--;
            end else begin
                j = $urandom_range(word_len - 1, 0);
                word_buf[j] ^= 8'(1 << $urandom_range(7, 0));
            end
            queue_word(CMD_LOOKUP, $urandom());
        end else if (pick < 93) begin
            make_word(rand_len());
            queue_word(CMD_LOOKUP, $urandom());
        end else begin
            make_word(NAME_MAX_DEF + 1 + $urandom_range(8, 0));
            queue_word($urandom_range(1, 0) ? CMD_LOOKUP : CMD_INSERT, rand_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // Directed: empty lookup, fold in both directions, the fold edge,
        // a zero byte, extreme values and a duplicate name
        word_len = 1;
        word_buf[0] = 8'h61;  queue_word(CMD_LOOKUP, $urandom());      // 'a', empty store
        word_buf[0] = 8'h5A;  queue_word(CMD_INSERT, 32'hFFFF_FFFF);   // 'Z'
        word_buf[0] = 8'h7A;  queue_word(CMD_LOOKUP, $urandom());      // 'z' folds to 'Z'
        word_buf[0] = 8'h3B;  queue_word(CMD_INSERT, 32'h0000_0000);   // ';'
        word_buf[0] = 8'h5B;  queue_word(CMD_LOOKUP, $urandom());      // '[' folds to ';'
        word_len = 2;
        word_buf[0] = 8'h00;
        word_buf[1] = 8'hFF;  queue_word(CMD_INSERT, 32'h1234_5678);
        word_buf[1] = 8'hDF;  queue_word(CMD_LOOKUP, $urandom());      // zero byte, 0xFF folded
        word_len = 1;
        word_buf[0] = 8'h3A;  queue_word(CMD_LOOKUP, $urandom());      // ':' is not 'Z'
        word_buf[0] = 8'h5A;  queue_word(CMD_INSERT, 32'h8000_0001);   // rebind 'Z'
        queue_word(CMD_LOOKUP, $urandom());                            // later record wins

        // Random names in three idling phases
        while (items_queued < 250)
            queue_random_name();
        phase1_end = items_queued;
        while (items_queued < 500)
            queue_random_name();
        phase2_end = items_queued;
        while (items_queued < 750)
            queue_random_name();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for the last answer, then watch for stray results
        while (items_taken != items_queued || answers_due.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wdl_pkg.sv
hw/rtl/wdl_front.sv
hw/rtl/wdl_queue.sv
hw/rtl/wdl_back.sv
hw/rtl/word_dictionary_lookup.sv
tb/tb.sv
